// File: rtl/core/cphm_pkg.sv
// Package: types, opcodes, states and constants of the chained pointer hash map.
package cphm_pkg;

    localparam int DEF_MAX_BUCKETS  = 256;
    localparam int DEF_POOL_ENTRIES = 1024;
    localparam int CFG_W            = 9;
    localparam int SUM_W            = 18;
    localparam int REM_W            = CFG_W + 1;
    localparam int KEY_W            = 64;
    localparam int VAL_W            = 64;
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 9'd256;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       bucket_index;
        logic             found;
        logic [VAL_W-1:0] value_out;
        logic             status;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQ,
        ST_MOD,
        ST_RD_HT,
        ST_HT,
        ST_ALLOC,
        ST_ALLOC_WT,
        ST_INS_W1,
        ST_INS_W2,
        ST_WALK,
        ST_CMP,
        ST_RM_W1,
        ST_RM_W2,
        ST_DONE
    } t_state;

endpackage

// File: rtl/core/chained_pointer_hash_map.sv
// Top level: chained hash map over a fixed entry pool, one operation per transfer.
// After reset the block sweeps all MAX_BUCKETS buckets to empty their heads and tails and
// takes no transfer meanwhile. Each operation then sums the squares of the four low key
// bytes on one shared multiplier, runs a bit-serial modulo by the bucket count, reads the
// bucket, compares chain entries one by one until a match or the end of the walk, does
// allocation and updates, registers the result and returns to idle before the next
// transfer. The input stalls until the result is registered, and a stalled result
// holds the block in its last state.
module chained_pointer_hash_map #(
    parameter int MAX_BUCKETS  = cphm_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_ENTRIES = cphm_pkg::DEF_POOL_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cphm_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cphm_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cphm_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int IW = $clog2(POOL_ENTRIES + 1);
    localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);
    localparam int CW = cphm_pkg::CFG_W;
    localparam int SW = cphm_pkg::SUM_W;
    localparam int RW = cphm_pkg::REM_W;
    localparam int KW = cphm_pkg::KEY_W;
    localparam int VW = cphm_pkg::VAL_W;

    logic [IW-1:0] m_head [MAX_BUCKETS];
    logic [IW-1:0] m_tail [MAX_BUCKETS];
    logic [KW-1:0] m_key  [POOL_ENTRIES];
    logic [VW-1:0] m_val  [POOL_ENTRIES];
    logic [IW-1:0] m_next [POOL_ENTRIES];
    logic [IW-1:0] m_prev [POOL_ENTRIES];

    logic [IW-1:0] m_head_q, m_tail_q, m_next_q, m_prev_q;
    logic [KW-1:0] m_key_q;
    logic [VW-1:0] m_val_q;

    cphm_pkg::t_state r_state, n_state;
    logic [1:0]    r_op, n_op;
    logic [KW-1:0] r_key, n_key;
    logic [VW-1:0] r_val, n_val;
    logic [SW-1:0] r_sum, n_sum;
    logic [4:0]    r_cnt, n_cnt;
    logic [RW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_div, n_div;
    logic [IW-1:0] r_head, n_head, r_tail, n_tail, r_cur, n_cur;
    logic [IW-1:0] r_nx, n_nx, r_pv, n_pv;
    logic          r_found, n_found, r_status, n_status;
    logic [VW-1:0] r_vout, n_vout;
    logic [IW-1:0] r_free, n_free, r_bump, n_bump;
    logic [BW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_cfg;
    logic          r_o_valid, n_o_valid;
    cphm_pkg::t_out_item r_o_item, n_o_item;

    logic          hd_we, tl_we;
    logic [BW-1:0] ht_waddr;
    logic [IW-1:0] hd_wdata, tl_wdata;
    logic          ent_we, nx_we, pv_we;
    logic [IW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata;
    logic [BW-1:0] bkt;
    logic [7:0]    sq_byte;
    logic [15:0]   sq;
    logic [RW-1:0] rem_sh;
    logic [IW-1:0] head_new;
    logic [CW-1:0] cfg_eff;

    assign bkt     = BW'(r_rem);
    assign sq_byte = r_key[8*r_cnt[1:0] +: 8];
    assign sq      = sq_byte * sq_byte;
    assign rem_sh  = {r_rem[RW-2:0], r_sum[r_cnt]};
    assign head_new = (r_cur == r_head) ? r_nx : r_head;
    assign cfg_eff = (r_cfg == '0) ? CW'(1)
                   : ((32'(r_cfg) > 32'(MAX_BUCKETS)) ? CW'(MAX_BUCKETS) : r_cfg);

    always_ff @(posedge i_clk) begin
        if (hd_we) m_head[ht_waddr] <= hd_wdata;
        if (tl_we) m_tail[ht_waddr] <= tl_wdata;
        m_head_q <= m_head[bkt];
        m_tail_q <= m_tail[bkt];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            m_key[r_cur[AW-1:0]] <= r_key;
            m_val[r_cur[AW-1:0]] <= r_val;
        end
        if (nx_we) m_next[nx_waddr[AW-1:0]] <= nx_wdata;
        if (pv_we) m_prev[pv_waddr[AW-1:0]] <= pv_wdata;
        m_key_q  <= m_key[r_cur[AW-1:0]];
        m_val_q  <= m_val[r_cur[AW-1:0]];
        m_next_q <= m_next[r_cur[AW-1:0]];
        m_prev_q <= m_prev[r_cur[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cphm_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_free    <= '0;
            r_bump    <= '0;
            r_cfg     <= cphm_pkg::BUCKET_COUNT_RST;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_free    <= n_free;
            r_bump    <= n_bump;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_sum    <= n_sum;
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_cur    <= n_cur;
        r_nx     <= n_nx;
        r_pv     <= n_pv;
        r_found  <= n_found;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_o_item <= n_o_item;
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op; n_key = r_key; n_val = r_val;
        n_sum = r_sum; n_cnt = r_cnt; n_rem = r_rem; n_div = r_div;
        n_head = r_head; n_tail = r_tail; n_cur = r_cur;
        n_nx = r_nx; n_pv = r_pv;
        n_found = r_found; n_status = r_status; n_vout = r_vout;
        n_free = r_free; n_bump = r_bump; n_clr = r_clr;
        n_o_item = r_o_item;
        n_o_valid = r_o_valid && i_out_stall;
        hd_we = 1'b0; tl_we = 1'b0; ht_waddr = bkt;
        hd_wdata = NIL; tl_wdata = NIL;
        ent_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        nx_waddr = r_cur; nx_wdata = NIL;
        pv_waddr = r_cur; pv_wdata = r_tail;
        unique case (r_state)
            cphm_pkg::ST_CLEAR: begin
                hd_we = 1'b1; tl_we = 1'b1; ht_waddr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == BW'(MAX_BUCKETS - 1)) n_state = cphm_pkg::ST_IDLE;
            end
            cphm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_in_item.opcode;
                    n_key = i_in_item.key;
                    n_val = i_in_item.value_in;
                    n_sum = '0; n_cnt = '0; n_rem = '0;
                    n_div = cfg_eff;
                    n_found = 1'b0; n_status = 1'b0; n_vout = '0;
                    n_state = cphm_pkg::ST_SQ;
                end
            end
            cphm_pkg::ST_SQ: begin
                n_sum = r_sum + SW'(sq);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_cnt = 5'(SW - 1);
                    n_state = cphm_pkg::ST_MOD;
                end
            end
            cphm_pkg::ST_MOD: begin
                n_rem = (rem_sh >= RW'(r_div)) ? rem_sh - RW'(r_div) : rem_sh;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = cphm_pkg::ST_RD_HT;
            end
            cphm_pkg::ST_RD_HT: n_state = cphm_pkg::ST_HT;
            cphm_pkg::ST_HT: begin
                n_head = m_head_q;
                n_tail = m_tail_q;
                unique case (r_op) inside
                    cphm_pkg::OP_INSERT: begin
                        n_cur = r_free;
                        if (r_free >= NIL) begin
                            n_status = 1'b1;
                            n_state = cphm_pkg::ST_DONE;
                        end else if (r_free == r_bump) begin
                            n_free = r_free + 1'b1;
                            n_bump = r_bump + 1'b1;
                            n_state = cphm_pkg::ST_INS_W1;
                        end else begin
                            n_state = cphm_pkg::ST_ALLOC;
                        end
                    end
                    cphm_pkg::OP_REMOVE, cphm_pkg::OP_LOOKUP: begin
                        n_cur = m_head_q;
                        if (r_op == cphm_pkg::OP_REMOVE && r_key == '0)
                            n_state = cphm_pkg::ST_DONE;
                        else
                            n_state = cphm_pkg::ST_WALK;
                    end
                    default: n_state = cphm_pkg::ST_DONE;
                endcase
            end
            cphm_pkg::ST_ALLOC: n_state = cphm_pkg::ST_ALLOC_WT;
            cphm_pkg::ST_ALLOC_WT: begin
                n_free = m_next_q;
                n_state = cphm_pkg::ST_INS_W1;
            end
            cphm_pkg::ST_INS_W1: begin
                ent_we = 1'b1;
                nx_we = 1'b1; nx_waddr = r_cur; nx_wdata = NIL;
                pv_we = 1'b1; pv_waddr = r_cur; pv_wdata = r_tail;
                tl_we = 1'b1; tl_wdata = r_cur;
                hd_we = (r_head >= NIL); hd_wdata = r_cur;
                n_state = (r_head >= NIL) ? cphm_pkg::ST_DONE : cphm_pkg::ST_INS_W2;
            end
            cphm_pkg::ST_INS_W2: begin
                nx_we = 1'b1; nx_waddr = r_tail; nx_wdata = r_cur;
                n_state = cphm_pkg::ST_DONE;
            end
            cphm_pkg::ST_WALK: begin
                n_state = (r_cur >= NIL) ? cphm_pkg::ST_DONE : cphm_pkg::ST_CMP;
            end
            cphm_pkg::ST_CMP: begin
                if (m_key_q == r_key) begin
                    n_found = 1'b1;
                    n_vout = m_val_q;
                    n_nx = m_next_q;
                    n_pv = m_prev_q;
                    n_state = (r_op == cphm_pkg::OP_REMOVE) ? cphm_pkg::ST_RM_W1
                                                             : cphm_pkg::ST_DONE;
                end else begin
                    n_cur = m_next_q;
                    n_state = cphm_pkg::ST_WALK;
                end
            end
            cphm_pkg::ST_RM_W1: begin
                hd_we = (r_cur == r_head); hd_wdata = r_nx;
                tl_we = (r_cur == r_tail) && (r_cur == head_new || r_nx >= NIL);
                tl_wdata = (head_new >= NIL) ? NIL : r_pv;
                pv_we = (r_nx < NIL); pv_waddr = r_nx;
                pv_wdata = (head_new == r_nx) ? NIL : r_pv;
                nx_we = 1'b1; nx_waddr = r_cur; nx_wdata = r_free;
                n_free = r_cur;
                n_state = (r_cur != r_head && r_pv < NIL) ? cphm_pkg::ST_RM_W2
                                                          : cphm_pkg::ST_DONE;
            end
            cphm_pkg::ST_RM_W2: begin
                nx_we = 1'b1; nx_waddr = r_pv; nx_wdata = r_nx;
                n_state = cphm_pkg::ST_DONE;
            end
            cphm_pkg::ST_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid = 1'b1;
                    n_o_item.bucket_index = r_rem[7:0];
                    n_o_item.found = r_found;
                    n_o_item.value_out = r_vout;
                    n_o_item.status = r_status;
                    n_state = cphm_pkg::ST_IDLE;
                end
            end
            default: n_state = cphm_pkg::ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != cphm_pkg::ST_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;
    assign o_cfg_ready = 1'b1;

endmodule

// File: rtl/core/cphm_checker.sv
// Checker: port-level properties of the chained pointer hash map, bound to the top level.
module cphm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cphm_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output transfer changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted again without processing");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.found && o_out_item.status))
        else $error("found and pool-full both set");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |-> o_out_item.value_out == '0)
        else $error("miss with nonzero value");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind chained_pointer_hash_map cphm_checker u_cphm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// File: tb/sv/cphm_checker.sv
// Checker: watches the hash map channels, predicts each result and compares it.
`timescale 1ns / 100ps
module cphm_scoreboard (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  cphm_pkg::t_in_item         i_in_item,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  cphm_pkg::t_out_item        i_out_item,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [cphm_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);
    import cphm_pkg::*;

    localparam int NB  = DEF_MAX_BUCKETS;
    localparam int NP  = DEF_POOL_ENTRIES;
    localparam int NIL = NP;

    int              bucket_first [NB];
    int              bucket_last  [NB];
    logic [63:0]     slot_key     [NP];
    logic [63:0]     slot_val     [NP];
    int              slot_link    [NP];
    int              slot_back    [NP];
    int              spare_head;
    logic [CFG_W-1:0] modulus;
    t_out_item       expected_results[$];

    function automatic int bucket_of(input logic [63:0] key);
        int sum;
        int n;
        sum = 0;
        for (int i = 0; i < 4; i++) sum += int'(key[8*i +: 8]) * int'(key[8*i +: 8]);
        n = int'(modulus);
        if (n == 0) n = 1;
        if (n > NB) n = NB;
        return sum % n;
    endfunction

    function automatic int oldest_match(input int b, input logic [63:0] key);
        int e;
        int steps;
        e = bucket_first[b];
        steps = 0;
        while (e < NIL && steps < NP) begin
            if (slot_key[e] == key) return e;
            e = slot_link[e];
            steps++;
        end
        return NIL;
    endfunction

    function automatic t_out_item apply_op(input t_in_item it);
        t_out_item r;
        int b;
        int e;
        int p;
        int n;
        b = bucket_of(it.key);
        r = '0;
        r.bucket_index = b[7:0];
        case (t_opcode'(it.opcode))
            OP_INSERT: begin
                e = spare_head;
                if (e >= NIL) begin
                    r.status = 1'b1;
                end else begin
                    spare_head = slot_link[e];
                    slot_key[e] = it.key;
                    slot_val[e] = it.value_in;
                    slot_link[e] = NIL;
                    slot_back[e] = bucket_last[b];
                    if (bucket_first[b] >= NIL) bucket_first[b] = e;
                    else slot_link[bucket_last[b]] = e;
                    bucket_last[b] = e;
                end
            end
            OP_REMOVE: begin
                e = (it.key != 0) ? oldest_match(b, it.key) : NIL;
                if (e < NIL) begin
                    p = slot_back[e];
                    n = slot_link[e];
                    r.found = 1'b1;
                    r.value_out = slot_val[e];
                    if (e == bucket_first[b]) bucket_first[b] = n;
                    else if (p < NIL) slot_link[p] = n;
                    if (e == bucket_last[b] && (e == bucket_first[b] || n >= NIL))
                        bucket_last[b] = (bucket_first[b] >= NIL) ? NIL : p;
                    if (n < NIL) slot_back[n] = (bucket_first[b] == n) ? NIL : p;
                    slot_link[e] = spare_head;
                    spare_head = e;
                end
            end
            OP_LOOKUP: begin
                e = oldest_match(b, it.key);
                if (e < NIL) begin
                    r.found = 1'b1;
                    r.value_out = slot_val[e];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item x;
        if (!i_rst_n) begin
            modulus = BUCKET_COUNT_RST;
            for (int i = 0; i < NB; i++) begin
                bucket_first[i] = NIL;
                bucket_last[i] = NIL;
            end
            for (int i = 0; i < NP; i++) begin
                slot_key[i] = '0;
                slot_val[i] = '0;
                slot_back[i] = 0;
                slot_link[i] = i + 1;
            end
            spare_head = 0;
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) modulus = i_cfg_data;
            if (i_in_valid && !i_in_stall) expected_results.push_back(apply_op(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_item);
                    o_errors++;
                end else begin
                    x = expected_results.pop_front();
                    if (x.bucket_index !== i_out_item.bucket_index) begin
                        $display("%0t: bucket_index expected %0d actual %0d", $time,
                                 x.bucket_index, i_out_item.bucket_index);
                        o_errors++;
                    end
                    if (x.found !== i_out_item.found) begin
                        $display("%0t: found expected %0d actual %0d", $time,
                                 x.found, i_out_item.found);
                        o_errors++;
                    end
                    if (x.value_out !== i_out_item.value_out) begin
                        $display("%0t: value_out expected %h actual %h", $time,
                                 x.value_out, i_out_item.value_out);
                        o_errors++;
                    end
                    if (x.status !== i_out_item.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 x.status, i_out_item.status);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule

// File: tb/sv/chained_pointer_hash_map_tb.sv
// Testbench top: stimulus, idling, watchdog and verdict for the chained pointer hash map.
`timescale 1ns / 100ps
module chained_pointer_hash_map_tb;
    import cphm_pkg::*;

    localparam int STALL_LIMIT = 30000;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    t_in_item           in_item;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    int                 errors;
    int                 pending;
    bit                 idle_on;
    int                 stall_burst = 0;
    int                 quiet_cycles = 0;
    int                 sent;
    int                 cfg_writes;
    logic [63:0]        key_set[$];
    logic [63:0]        filled[$];

    chained_pointer_hash_map u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    cphm_scoreboard u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (stall_burst > 0) begin
            out_stall <= 1'b1;
            stall_burst <= stall_burst - 1;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            out_stall <= 1'b1;
            stall_burst <= $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_op(input t_opcode op, input logic [63:0] key, input logic [63:0] val);
        t_in_item it;
        it.opcode = op;
        it.key = key;
        it.value_in = val;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_buckets(input logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic random_phase(input int count);
        int r;
        logic [63:0] k;
        key_set.delete();
        for (int i = 0; i < 12; i++) key_set.push_back(rand64());
        key_set[0][31:0] = key_set[1][31:0];
        key_set[2] = '0;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 4) == 0) ? rand64() : key_set[$urandom_range(0, 11)];
            if (r < 40) send_op(OP_INSERT, k, rand64());
            else if (r < 68) send_op(OP_REMOVE, k, rand64());
            else if (r < 96) send_op(OP_LOOKUP, k, rand64());
            else send_op(OP_NONE, k, rand64());
        end
    endtask

    initial begin
        logic [CFG_W-1:0] settings[8];
        logic [63:0] k;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_on = 1'b1;
        sent = 0;
        cfg_writes = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_op(OP_INSERT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(OP_INSERT, '1, 64'd0);
        send_op(OP_INSERT, 64'h0123, 64'hA1);
        send_op(OP_INSERT, 64'h0123, 64'hA2);
        send_op(OP_INSERT, 64'h1_0000_0123, 64'hA3);
        send_op(OP_LOOKUP, 64'd0, 64'd0);
        send_op(OP_REMOVE, 64'd0, 64'd0);
        send_op(OP_LOOKUP, 64'd0, 64'd0);
        send_op(OP_LOOKUP, '1, 64'd0);
        send_op(OP_LOOKUP, 64'h0123, 64'd0);
        send_op(OP_REMOVE, 64'h0123, 64'd0);
        send_op(OP_LOOKUP, 64'h0123, 64'd0);
        send_op(OP_LOOKUP, 64'h1_0000_0123, 64'd0);
        send_op(OP_REMOVE, 64'h0123, 64'd0);
        send_op(OP_REMOVE, 64'h0123, 64'd0);
        send_op(OP_LOOKUP, 64'h2345, 64'd0);
        send_op(OP_NONE, 64'hFFFF_FFFF, '1);
        send_op(OP_REMOVE, '1, 64'd0);

        settings = '{9'd1, 9'd0, 9'd511, 9'd257, 9'd7, 9'd256, 9'd100, 9'd255};
        foreach (settings[i]) begin
            write_buckets(settings[i]);
            random_phase(85);
        end

        write_buckets(9'd256);
        for (int i = 0; i < 1100; i++) begin
            k = rand64();
            filled.push_back(k);
            send_op(OP_INSERT, k, rand64());
        end

        write_buckets(9'($urandom_range(2, 256)));
        idle_on = 1'b0;
        for (int i = 0; i < 150; i++) begin
            k = filled[$urandom_range(0, filled.size() - 1)];
            send_op((i % 3 == 0) ? OP_LOOKUP : OP_REMOVE, k, rand64());
        end

        drain();
        repeat (60) @(posedge i_clk);
        $display("Sent %0d operations over %0d bucket count writes, pool filled past capacity.",
                 sent, cfg_writes);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/cphm_pkg.sv
rtl/core/chained_pointer_hash_map.sv
rtl/core/cphm_checker.sv
tb/sv/cphm_checker.sv
tb/sv/chained_pointer_hash_map_tb.sv
